>>> sv/ss_pkg.sv
// ----------------------------------------------------------------------------
// Stride scheduler package
// Field widths, entry and chain record types and saturating arithmetic
// shared by the job cells, the stride divider and the top level.
// ----------------------------------------------------------------------------
package ss_pkg;

  localparam int ID_W   = 8;
  localparam int TKT_W  = 14;
  localparam int SVC_W  = 16;
  localparam int NUM_W  = 16;
  localparam int TIME_W = 40;
  localparam int COST_W = 16;

  localparam int MAX_JOBS_DEF   = 16;
  localparam int STRIDE_NUM_DEF = 10000;

  localparam logic [TKT_W-1:0]  STRIDE_MAX = {TKT_W{1'b1}};
  localparam logic [TIME_W-1:0] ONE_TICK   = TIME_W'(256);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TKT_W-1:0]  stride;
    logic [TIME_W-1:0] pass;
    logic [SVC_W-1:0]  remain;
    logic [SVC_W-1:0]  service;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] pass;
    logic [ID_W-1:0]   id;
    logic              first;
    logic              last;
  } carry_t;

  typedef struct packed {
    logic             load_en;
    logic [ID_W-1:0]  load_id;
    logic [TKT_W-1:0] load_stride;
    logic [SVC_W-1:0] load_service;
    logic             upd_en;
    logic             remove;
  } cell_ctrl_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> sv/ss_div.sv
// ----------------------------------------------------------------------------
// Stride divider
// Restoring divider that computes a constant numerator over the ticket
// count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ss_div #(
  parameter int NUMER = ss_pkg::STRIDE_NUM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ss_pkg::TKT_W-1:0] divisor,
  output logic                     done,
  output logic [ss_pkg::NUM_W-1:0] quot
);
  import ss_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic [TKT_W-1:0]  rem_r;
  logic [TKT_W-1:0]  dvs_r;
  logic [NUM_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [TKT_W:0]    rem_sh;
  logic [TKT_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && step_r == STEP_W'(NUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= NUM_W'(NUMER);
      dvs_r  <= (divisor == '0) ? TKT_W'(1) : divisor;
      step_r <= '0;
    end else if (run_r) begin
      rem_r  <= ge ? diff[TKT_W-1:0] : rem_sh[TKT_W-1:0];
      quo_r  <= {quo_r[NUM_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> sv/ss_cell.sv
// ----------------------------------------------------------------------------
// Job cell
// Holds one table entry, forwards the running minimum pass to its right
// neighbor every cycle and takes its right neighbor's entry on a removal.
// ----------------------------------------------------------------------------
module ss_cell #(
  parameter int IDX_W = 4,
  parameter int SLOT  = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ss_pkg::cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0]         load_slot,
  input  logic [IDX_W-1:0]         upd_slot,
  input  ss_pkg::entry_t           next_entry,
  input  ss_pkg::carry_t           carry_in,
  input  logic [IDX_W-1:0]         carry_in_idx,
  output ss_pkg::entry_t           entry,
  output ss_pkg::carry_t           carry_out,
  output logic [IDX_W-1:0]         carry_out_idx
);
  import ss_pkg::*;

  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(SLOT);

  entry_t           entry_r;
  entry_t           entry_nxt;
  carry_t           carry_r;
  carry_t           carry_nxt;
  logic [IDX_W-1:0] cidx_r;
  logic [IDX_W-1:0] cidx_nxt;
  logic             take_own;

  assign take_own = entry_r.valid && (!carry_in.valid || entry_r.pass < carry_in.pass);

  always_comb begin
    if (take_own) begin
      carry_nxt.valid = 1'b1;
      carry_nxt.pass  = entry_r.pass;
      carry_nxt.id    = entry_r.id;
      carry_nxt.first = entry_r.service == entry_r.remain;
      carry_nxt.last  = entry_r.remain <= SVC_W'(1);
      cidx_nxt        = MY_SLOT;
    end else begin
      carry_nxt = carry_in;
      cidx_nxt  = carry_in_idx;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load_en && load_slot == MY_SLOT) begin
      entry_nxt.valid   = 1'b1;
      entry_nxt.id      = ctrl.load_id;
      entry_nxt.stride  = ctrl.load_stride;
      entry_nxt.pass    = '0;
      entry_nxt.remain  = ctrl.load_service;
      entry_nxt.service = ctrl.load_service;
    end else if (ctrl.upd_en && ctrl.remove && MY_SLOT >= upd_slot) begin
      entry_nxt = next_entry;
    end else if (ctrl.upd_en && !ctrl.remove && MY_SLOT == upd_slot) begin
      entry_nxt.remain = entry_r.remain - SVC_W'(1);
      entry_nxt.pass   = sat_add(entry_r.pass, TIME_W'(entry_r.stride));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      carry_r <= '0;
      cidx_r  <= '0;
    end else begin
      entry_r <= entry_nxt;
      carry_r <= carry_nxt;
      cidx_r  <= cidx_nxt;
    end
  end

  assign entry         = entry_r;
  assign carry_out     = carry_r;
  assign carry_out_idx = cidx_r;

endmodule

>>> sv/stride_scheduler.sv
// ----------------------------------------------------------------------------
// Stride scheduler
// Job table as a row of cells with a stride divider and a tick sequencer.
// ----------------------------------------------------------------------------
// Input beats carry a mode in in_tuser: 0 loads a job (id, tickets, service
// time in in_tdata), 1 requests one scheduling tick. Loads give no output;
// each tick gives exactly one output beat with the job run, its first-run
// and completion flags and the clock after the tick.
// A load waits in S_DIV for the bit-serial stride divider; a load into a
// full table is dropped. A tick with jobs steps through S_SCAN, S_APPLY
// and S_RESULT: the minimum pass ripples through the cell row one cell per
// cycle. A tick on an empty table goes straight to S_RESULT. One beat is
// in work at a time.
// The output register holds a result until out_tready; the block returns to
// accepting beats meanwhile, and a following tick waits only at its final
// step if the previous result has not been taken.
// Reset empties the table, clears the clock and zeroes switch_cost. cfg_wr_en
// writes it; the user must use it only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module stride_scheduler #(
  parameter int MAX_JOBS         = ss_pkg::MAX_JOBS_DEF,
  parameter int STRIDE_NUMERATOR = ss_pkg::STRIDE_NUM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ss_pkg::COST_W-1:0]     cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // job_id[7:0], tickets[21:8], run_ticks[37:22], zero[39:38]
  input  logic [ss_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // ran_job[7:0], idle[8], first_run[9], completed[10], time_now[50:11],
  // zero[55:51]
  output logic [ss_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ss_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_APPLY  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  scan_r;
  logic [TIME_W-1:0] clock_r;
  logic [COST_W-1:0] cost_r;
  logic [ID_W-1:0]   ld_id_r;
  logic [SVC_W-1:0]  ld_svc_r;
  logic [ID_W-1:0]   res_id_r;
  logic              res_idle_r;
  logic              res_first_r;
  logic              res_done_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              in_fire;
  logic              is_tick;
  logic              full;
  logic [ID_W-1:0]   in_id;
  logic [TKT_W-1:0]  in_tickets;
  logic [SVC_W-1:0]  in_svc;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [TKT_W-1:0]  stride;
  logic              out_free;
  logic [TIME_W-1:0] time_final;
  cell_ctrl_t        ctrl;
  logic [IDX_W-1:0]  upd_slot;

  entry_t            entry_w [MAX_JOBS];
  carry_t            carry_w [MAX_JOBS];
  logic [IDX_W-1:0]  cidx_w  [MAX_JOBS];
  carry_t            carry_last;

  assign in_tready  = state_r == S_IDLE;
  assign in_fire    = in_tvalid && in_tready;
  assign is_tick    = in_tuser;
  assign in_id      = in_tdata[7:0];
  assign in_tickets = in_tdata[21:8];
  assign in_svc     = in_tdata[37:22];
  assign full       = count_r == CNT_W'(MAX_JOBS);
  assign out_free   = !out_valid_r || out_tready;
  assign carry_last = carry_w[MAX_JOBS-1];
  assign upd_slot   = cidx_w[MAX_JOBS-1];
  assign stride     = (div_quot > NUM_W'(STRIDE_MAX)) ? STRIDE_MAX : div_quot[TKT_W-1:0];
  assign time_final = res_done_r ? sat_add(clock_r, TIME_W'(cost_r)) : clock_r;

  ss_div #(
    .NUMER(STRIDE_NUMERATOR)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire && !is_tick && !full),
    .divisor(in_tickets),
    .done   (div_done),
    .quot   (div_quot)
  );

  always_comb begin
    ctrl.load_en      = (state_r == S_DIV) && div_done;
    ctrl.load_id      = ld_id_r;
    ctrl.load_stride  = stride;
    ctrl.load_service = ld_svc_r;
    ctrl.upd_en       = state_r == S_APPLY;
    ctrl.remove       = carry_last.last;
  end

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    entry_t           nb_entry;
    carry_t           c_in;
    logic [IDX_W-1:0] c_in_idx;

    if (i == MAX_JOBS - 1) begin : g_tail
      assign nb_entry = '0;
    end else begin : g_body
      assign nb_entry = entry_w[i+1];
    end

    if (i == 0) begin : g_head
      assign c_in     = '0;
      assign c_in_idx = '0;
    end else begin : g_chain
      assign c_in     = carry_w[i-1];
      assign c_in_idx = cidx_w[i-1];
    end

    ss_cell #(
      .IDX_W(IDX_W),
      .SLOT (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .load_slot    (count_r[IDX_W-1:0]),
      .upd_slot     (upd_slot),
      .next_entry   (nb_entry),
      .carry_in     (c_in),
      .carry_in_idx (c_in_idx),
      .entry        (entry_w[i]),
      .carry_out    (carry_w[i]),
      .carry_out_idx(cidx_w[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_tick) begin
            state_nxt = (count_r == '0) ? S_RESULT : S_SCAN;
          end else if (!full) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_r == IDX_W'(MAX_JOBS - 1)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      clock_r     <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cost_r <= cfg_wr_data;
      end
      if (ctrl.load_en) begin
        count_r <= count_r + CNT_W'(1);
      end else if (state_r == S_APPLY && carry_last.last) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (state_r == S_APPLY) begin
        clock_r <= sat_add(clock_r, ONE_TICK);
      end else if (state_r == S_RESULT && out_free) begin
        clock_r <= time_final;
      end
      if (state_r == S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_r   <= '0;
      ld_id_r  <= in_id;
      ld_svc_r <= (in_svc == '0) ? SVC_W'(1) : in_svc;
    end else if (state_r == S_SCAN) begin
      scan_r <= scan_r + IDX_W'(1);
    end
    if (in_fire && is_tick) begin
      res_id_r    <= '0;
      res_idle_r  <= 1'b1;
      res_first_r <= 1'b0;
      res_done_r  <= 1'b0;
    end else if (state_r == S_APPLY) begin
      res_id_r    <= carry_last.id;
      res_idle_r  <= 1'b0;
      res_first_r <= carry_last.first;
      res_done_r  <= carry_last.last;
    end
    if (state_r == S_RESULT && out_free) begin
      out_data_r <= {(OUT_DATA_W - TIME_W - ID_W - 3)'(0), time_final,
                     res_done_r, res_first_r, res_idle_r, res_id_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JOBS))
    else $error("job count exceeds table size");

  a_apply_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |-> carry_last.valid)
    else $error("tick applied without a selected job");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && carry_last.last) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("completed job did not leave the table");

  a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_en |-> !full)
    else $error("load written into a full table");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Stride scheduler testbench
// Streams job loads and scheduling ticks into the block and checks every
// tick result against an in-bench model of the job table and clock. Both
// stream sides idle at random, the receiver holds off once for a long
// stretch, and switch_cost is rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ss_pkg::*;

  localparam int JOB_SLOTS    = MAX_JOBS_DEF;
  localparam int STRIDE_NUM   = STRIDE_NUM_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_WAIT  = 40;
  localparam int LONG_HOLD    = 500;
  localparam int IDLE_PCT     = 26;

  typedef enum logic {MODE_LOAD = 1'b0, MODE_TICK = 1'b1} beat_mode_e;

  typedef struct packed {
    beat_mode_e       mode;
    logic [ID_W-1:0]  id;
    logic [TKT_W-1:0] tickets;
    logic [SVC_W-1:0] service;
  } sched_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]   ran_job;
    logic              idle;
    logic              first_run;
    logic              completed;
    logic [TIME_W-1:0] time_now;
  } tick_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [COST_W-1:0]     cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  sched_beat_t  beats_to_send[$];
  tick_result_t tick_results_due[$];

  int errors = 0;
  int cycle_count = 0;
  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  int rx_long_req = 0;
  int rx_long_seen = 0;
  int rx_hold_left = 0;

  logic [ID_W-1:0]   tbl_id      [JOB_SLOTS];
  logic [TKT_W-1:0]  tbl_stride  [JOB_SLOTS];
  logic [TIME_W-1:0] tbl_pass    [JOB_SLOTS];
  logic [SVC_W-1:0]  tbl_remain  [JOB_SLOTS];
  logic [SVC_W-1:0]  tbl_service [JOB_SLOTS];
  int                tbl_count = 0;
  logic [TIME_W-1:0] sim_clock = '0;
  logic [COST_W-1:0] sim_switch_cost = '0;

  stride_scheduler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] add_sat40(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    if (total[TIME_W]) begin
      return {TIME_W{1'b1}};
    end
    return total[TIME_W-1:0];
  endfunction

  function automatic string describe(input tick_result_t r);
    return $sformatf("job %0d idle %0b first %0b done %0b clock %0h",
                     r.ran_job, r.idle, r.first_run, r.completed, r.time_now);
  endfunction

  task automatic table_load(input sched_beat_t b);
    int unsigned tk;
    int unsigned st;
    logic [SVC_W-1:0] svc;
    if (tbl_count >= JOB_SLOTS) begin
      return;
    end
    tk = (b.tickets == 0) ? 1 : b.tickets;
    svc = (b.service == 0) ? SVC_W'(1) : b.service;
    st = STRIDE_NUM / tk;
    if (st > STRIDE_MAX) begin
      st = STRIDE_MAX;
    end
    tbl_id[tbl_count] = b.id;
    tbl_stride[tbl_count] = TKT_W'(st);
    tbl_pass[tbl_count] = '0;
    tbl_remain[tbl_count] = svc;
    tbl_service[tbl_count] = svc;
    tbl_count++;
  endtask

  task automatic table_tick(output tick_result_t r);
    int best;
    r = '0;
    if (tbl_count == 0) begin
      r.idle = 1'b1;
      r.time_now = sim_clock;
      return;
    end
    best = 0;
    for (int i = 1; i < tbl_count; i++) begin
      if (tbl_pass[i] < tbl_pass[best]) begin
        best = i;
      end
    end
    r.ran_job = tbl_id[best];
    r.first_run = (tbl_service[best] == tbl_remain[best]);
    sim_clock = add_sat40(sim_clock, TIME_W'(256));
    if (tbl_remain[best] != 0) begin
      tbl_remain[best] = tbl_remain[best] - 1'b1;
    end
    if (tbl_remain[best] == 0) begin
      r.completed = 1'b1;
      for (int i = best; i + 1 < tbl_count; i++) begin
        tbl_id[i] = tbl_id[i+1];
        tbl_stride[i] = tbl_stride[i+1];
        tbl_pass[i] = tbl_pass[i+1];
        tbl_remain[i] = tbl_remain[i+1];
        tbl_service[i] = tbl_service[i+1];
      end
      tbl_count--;
      sim_clock = add_sat40(sim_clock, TIME_W'(sim_switch_cost));
    end else begin
      tbl_pass[best] = add_sat40(tbl_pass[best], TIME_W'(tbl_stride[best]));
    end
    r.time_now = sim_clock;
  endtask

  function automatic sched_beat_t load_beat(input int id, input int tk, input int svc);
    sched_beat_t b;
    b.mode = MODE_LOAD;
    b.id = ID_W'(id);
    b.tickets = TKT_W'(tk);
    b.service = SVC_W'(svc);
    return b;
  endfunction

  function automatic sched_beat_t tick_beat();
    sched_beat_t b;
    b.mode = MODE_TICK;
    b.id = ID_W'($urandom);
    b.tickets = TKT_W'($urandom);
    b.service = SVC_W'($urandom);
    return b;
  endfunction

  function automatic sched_beat_t random_load();
    int pick_t;
    int pick_s;
    int tk;
    int svc;
    pick_t = $urandom_range(99);
    pick_s = $urandom_range(99);
    if (pick_t < 70) begin
      tk = $urandom_range(1, 100);
    end else if (pick_t < 90) begin
      tk = $urandom_range(1, 10000);
    end else begin
      tk = $urandom_range(0, 16383);
    end
    if (pick_s < 80) begin
      svc = $urandom_range(1, 4);
    end else if (pick_s < 95) begin
      svc = $urandom_range(5, 20);
    end else begin
      svc = 0;
    end
    return load_beat($urandom_range(0, 255), tk, svc);
  endfunction

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      beats_to_send = {beats_to_send, tick_beat()};
    end
  endtask

  task automatic queue_random(input int n);
    int made;
    int pick;
    int loads;
    int ticks;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        loads = 18;
        ticks = 0;
      end else if (pick < 14) begin
        loads = 0;
        ticks = 30;
      end else begin
        loads = $urandom_range(1, 3);
        ticks = $urandom_range(1, 16);
      end
      for (int i = 0; i < loads; i++) begin
        beats_to_send = {beats_to_send, random_load()};
      end
      queue_ticks(ticks);
      made += loads + ticks;
    end
  endtask

  task automatic queue_directed();
    queue_ticks(1);
    beats_to_send = {beats_to_send, load_beat(0, 0, 0)};
    queue_ticks(2);
    beats_to_send = {beats_to_send, load_beat(255, 1, 65535)};
    beats_to_send = {beats_to_send, load_beat(7, 16383, 2)};
    beats_to_send = {beats_to_send, load_beat(7, 10000, 1)};
    for (int k = 0; k < 13; k++) begin
      beats_to_send = {beats_to_send, load_beat(k + 10, k * 700 + 1, k % 3 + 1)};
    end
    beats_to_send = {beats_to_send, load_beat(99, 50, 5)};
    queue_ticks(4);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (beats_to_send.size() != 0 || in_tvalid || tick_results_due.size() != 0);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_switch_cost(input logic [COST_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    sim_switch_cost = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_inputs
    sched_beat_t nb;
    sched_beat_t seen;
    tick_result_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        seen.mode = beat_mode_e'(in_tuser);
        seen.id = in_tdata[7:0];
        seen.tickets = in_tdata[21:8];
        seen.service = in_tdata[37:22];
        if (seen.mode == MODE_TICK) begin
          table_tick(res);
          tick_results_due = {tick_results_due, res};
        end else begin
          table_load(seen);
        end
      end
      if (!in_tvalid || in_tready) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nb = beats_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nb.mode;
          in_tdata <= {2'b00, nb.service, nb.tickets, nb.id};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_long_seen != rx_long_req) begin
      rx_long_seen <= rx_long_req;
      rx_hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tick_result_t got;
    tick_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ran_job = out_tdata[7:0];
      got.idle = out_tdata[8];
      got.first_run = out_tdata[9];
      got.completed = out_tdata[10];
      got.time_now = out_tdata[50:11];
      if (tick_results_due.size() == 0) begin
        $display("%0t: unexpected result beat: %s", $realtime, describe(got));
        errors++;
      end else begin
        want = tick_results_due.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected %s, got %s", $realtime, describe(want),
                   describe(got));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_switch_cost(16'd300);
    queue_directed();
    wait_drained();

    write_switch_cost(16'hFFFF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(150);
    do begin
      @(negedge clk);
    end while (beats_to_send.size() != 0);
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    queue_random(150);
    wait_drained();

    write_switch_cost(16'd0);
    queue_random(100);
    queue_ticks(40);
    do begin
      @(negedge clk);
    end while (beats_to_send.size() > 30);
    rx_long_req = rx_long_req + 1;
    queue_random(200);
    wait_drained();

    write_switch_cost(16'd1);
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    write_switch_cost(COST_W'($urandom_range(0, 65535)));
    queue_random(200);
    wait_drained();

    if (errors == 0 && tick_results_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ss_pkg.sv
sv/ss_div.sv
sv/ss_cell.sv
sv/stride_scheduler.sv
tb/testbench.sv
